FILE: src/huffman_bit_packer_defines.svh
// Assertion macros shared by the bit packer modules.
// No dependencies; include by bare file name.
`ifndef HUFFMAN_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/hbp_pkg.sv
// Package for the bit packer: item structs, op codes, controller types.
// No dependencies; used by every module of the block except hbp_ram.
package hbp_pkg;

   localparam int MAX_CODE_LENGTH = 32;
   localparam int SYM_W           = 8;
   localparam int CODE_W          = 32;
   localparam int LEN_W           = 6;
   localparam int TABLE_DEPTH     = 256;
   localparam int ENTRY_W         = CODE_W + LEN_W;
   localparam int PEND_W          = 7;
   localparam int CNT_W           = 3;
   localparam int ACC_W           = PEND_W + CODE_W;
   localparam int TOT_W           = 6;
   localparam int BYTE_W          = 8;

   // Longest code the table keeps: bounded by the parameter and by the field width.
   localparam int LEN_LIMIT_INT = (MAX_CODE_LENGTH > CODE_W) ? CODE_W : MAX_CODE_LENGTH;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic flush;
      logic merge;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic ge8;
      logic last;
   } status_type;

endpackage

FILE: src/hbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/hbp_datapath.sv
// Datapath of the bit packer: code table, valid bits, bit accumulator, result register.
// Depends on hbp_pkg, hbp_ram and huffman_bit_packer_defines.svh.
`include "huffman_bit_packer_defines.svh"

module hbp_datapath
   import hbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   valid_hit_ff, valid_hit_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [PEND_W-1:0]      pend_ff, pend_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0]   load_len;
   logic [ENTRY_W-1:0] rd_entry;
   logic [LEN_W-1:0]   rd_len;
   logic [CODE_W-1:0]  code_la;
   logic [ACC_W-1:0]   merge_acc;
   logic [TOT_W-1:0]   merge_total;

   assign load_len = (req_item.code_length > LEN_LIMIT) ? LEN_LIMIT : req_item.code_length;

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (req_item.symbol),
      .wr_data ({load_len, req_item.code_bits}),
      .rd_en   (cmd.lookup),
      .rd_addr (req_item.symbol),
      .rd_data (rd_entry)
   );

   // Unloaded entry reads as length zero; its code bits never matter.
   assign rd_len = valid_hit_ff ? rd_entry[ENTRY_W-1 -: LEN_W] : '0;

   // Left-align the code so its first bit sits at the top; drops bits above the length.
   assign code_la     = rd_entry[CODE_W-1:0] << (LEN_W'(CODE_W) - rd_len);
   assign merge_acc   = {pend_ff, {CODE_W{1'b0}}} | ({code_la, {PEND_W{1'b0}}} >> count_ff);
   assign merge_total = TOT_W'(count_ff) + TOT_W'(rd_len);

   assign status.ge8  = (total_ff >= TOT_W'(BYTE_W));
   assign status.last = (total_ff < TOT_W'(2 * BYTE_W));

   always_comb begin
      valid_in     = valid_ff;
      valid_hit_in = valid_hit_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      pend_in      = pend_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      if (cmd.load) begin
         valid_in[req_item.symbol] = 1'b1;
      end
      if (cmd.lookup) begin
         valid_hit_in = valid_ff[req_item.symbol];
      end
      if (cmd.merge) begin
         acc_in   = merge_acc;
         total_in = merge_total;
      end
      if (cmd.step) begin
         rsp_in.packed_byte = acc_ff[ACC_W-1 -: BYTE_W];
         rsp_in.last_of_run = status.last;
         rsp_valid_in       = 1'b1;
         acc_in             = acc_ff << BYTE_W;
         total_in           = total_ff - TOT_W'(BYTE_W);
      end
      // Keep the leftover bits; subtracting eight leaves the low count bits alone.
      if (cmd.commit) begin
         pend_in  = cmd.step ? acc_ff[ACC_W-BYTE_W-1 -: PEND_W] : acc_ff[ACC_W-1 -: PEND_W];
         count_in = total_ff[CNT_W-1:0];
      end
      if (cmd.flush && (count_ff != '0)) begin
         rsp_in.packed_byte = {pend_ff, 1'b0};
         rsp_in.last_of_run = 1'b1;
         rsp_valid_in       = 1'b1;
         pend_in            = '0;
         count_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pend_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      valid_hit_ff <= valid_hit_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `HBP_ASSERT_NOW(a_step_has_byte, clock, reset, cmd.step, status.ge8, "step without a full byte")
   `HBP_ASSERT_NOW(a_pend_clean, clock, reset, 1'b1, (pend_ff & (7'h7f >> count_ff)) == 7'd0, "stale bits below pending count")
   `HBP_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid_ff && !rsp_ff.last_of_run, rsp_valid_ff, "byte run broken before its last byte")

endmodule

FILE: src/hbp_ctrl.sv
// Controller of the bit packer: accepts items and sequences the datapath.
// Depends on hbp_pkg.
module hbp_ctrl
   import hbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] op,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (op)
                  OP_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  OP_ENCODE: begin
                     cmd.lookup = 1'b1;
                     state_in   = ST_MERGE;
                  end
                  OP_FLUSH: begin
                     cmd.flush = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.ge8) begin
               cmd.step = 1'b1;
               if (status.last) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/huffman_bit_packer.sv
// Top level of the Huffman bit packer: controller plus datapath.
// Depends on hbp_pkg, hbp_ctrl, hbp_datapath (and through it hbp_ram).
//
// Usage:
//   Input: drive req_item and raise start; the item is taken at a rising edge where
//   start is high and busy is low. op selects load (write one table entry), encode
//   (append the symbol's code) or flush (pad the partial byte with zeros and emit it).
//   Output: each packed byte shows on rsp_item for exactly one cycle with rsp_strobe
//   high; last_of_run marks the final byte an item produced. The receiver cannot stall,
//   so every byte must be taken in the cycle it is shown.
// Timing:
//   Load and flush never raise busy; a flush byte shows in the cycle after acceptance.
//   Encode holds busy while the merge state waits on the registered table read and
//   merges the code into the accumulator, then one byte drains per cycle, n bytes in
//   all, n being the number of bytes it completes (0 to 4). The first byte passes the
//   table read, the accumulator and the result register before it shows on rsp_item.
// Reset:
//   Clears the controller, the pending partial byte and every table entry's valid bit,
//   so all code lengths read as zero; an encode of an unloaded symbol emits nothing.
module huffman_bit_packer
   import hbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   cmd_type    cmd;
   status_type status;

   // Sequence accept, merge and drain.
   hbp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_item.op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Hold the code table, the bit accumulator and the result register.
   hbp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

FILE: tb/tb_huffman_bit_packer.sv
// Self-checking testbench for huffman_bit_packer: directed table rows, then random traffic.
// Depends on hbp_pkg and the huffman_bit_packer RTL; needs no other file.
module tb_huffman_bit_packer;
   import hbp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // op value 3 is left unused by the block
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         REPORT_LIMIT = 10;
   localparam int         RANDOM_ITEMS = 256;
   localparam int         DRAIN_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   huffman_bit_packer u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // One row of the directed table. n_typed < 0 means: take the bytes from the packer model.
   typedef struct {
      req_type    item;
      int         n_typed;
      logic [31:0] typed_bytes;
   } row_type;

   // Packer model state: codeword table plus the partial byte.
   logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
   logic [LEN_W-1:0]  len_tbl  [TABLE_DEPTH];
   logic [PEND_W-1:0] part_bits;
   logic [CNT_W-1:0]  part_count;

   // Bytes still owed by the block, oldest first.
   rsp_type owed_bytes [$];
   // Symbols loaded at some point with a nonzero length, so random encodes mostly hit real codes.
   logic [SYM_W-1:0] coded_syms [$];

   int  mismatches;
   int  bytes_checked;
   int  n_load, n_encode, n_flush, n_unused, n_four;
   bit  req_held;

   // ---------------------------------------------------------------------------
   // Clock and run limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Slowest legal run is roughly 280 items, each with the longest busy and gap: about 100 us.
   initial begin
      #2_000_000;
      $display("FAIL huffman_bit_packer");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Packer model: update table and partial byte, return the bytes an item makes
   // ---------------------------------------------------------------------------
   task automatic pack_item(input req_type it, output rsp_type made [$]);
      logic [LEN_W-1:0] len;
      logic [63:0]      acc;
      int               total;
      rsp_type          r;
      made = {};
      case (it.op)
         OP_LOAD: begin
            // saturate long loads to the table's limit
            code_tbl[it.symbol] = it.code_bits;
            len_tbl[it.symbol]  = (it.code_length > LEN_LIMIT) ? LEN_LIMIT : it.code_length;
         end
         OP_ENCODE: begin
            len = len_tbl[it.symbol];
            if (len != '0) begin
               // drop code bits above the length, append below the partial byte
               acc = (64'(part_bits) << len)
                     | (64'(code_tbl[it.symbol]) & ((64'd1 << len) - 64'd1));
               total = int'(part_count) + int'(len);
               while (total >= 8) begin
                  r.packed_byte = 8'(acc >> (total - 8));
                  r.last_of_run = (total - 8 < 8);
                  made = {made, r};
                  total -= 8;
               end
               part_count = CNT_W'(total);
               part_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
            end
         end
         OP_FLUSH: begin
            if (part_count != '0) begin
               // pad with zeros on the right
               r.packed_byte = 8'(16'(part_bits) << (8 - int'(part_count)));
               r.last_of_run = 1'b1;
               made = {made, r};
               part_bits  = '0;
               part_count = '0;
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Sender: hold the item until accepted, queue its bytes, then idle for gap cycles
   // ---------------------------------------------------------------------------
   task automatic issue_item(input req_type it, input int n_typed, input logic [31:0] typed,
                             input int gap);
      rsp_type made [$];
      rsp_type r;
      req_item <= it;
      start    <= 1'b1;
      req_held  = 1'b1;
      // accepted at the first edge with busy low
      do @(posedge clock); while (busy !== 1'b0);
      pack_item(it, made);
      if (n_typed >= 0) begin
         made = {};
         for (int i = 0; i < n_typed; i++) begin
            r.packed_byte = typed[31 - 8*i -: 8];
            r.last_of_run = (i == n_typed - 1);
            made = {made, r};
         end
      end
      foreach (made[i]) owed_bytes = {owed_bytes, made[i]};
      case (it.op)
         OP_LOAD:   n_load++;
         OP_ENCODE: n_encode++;
         OP_FLUSH:  n_flush++;
         default:   n_unused++;
      endcase
      if (made.size() == 4) n_four++;
      if (it.op == OP_LOAD && it.code_length != '0) coded_syms = {coded_syms, it.symbol};
      if (gap > 0) begin
         start   <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every owed byte has come, then let the block settle.
   task automatic wait_idle();
      if (req_held) begin
         start   <= 1'b0;
         req_held = 1'b0;
      end
      while (owed_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic row_type mk_row(logic [1:0] op, logic [7:0] sym, logic [31:0] bits,
                                      logic [5:0] len, int n_typed, logic [31:0] typed);
      row_type r;
      r.item.op          = op;
      r.item.symbol      = sym;
      r.item.code_bits   = bits;
      r.item.code_length = len;
      r.n_typed          = n_typed;
      r.typed_bytes      = typed;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Checker: every strobe must match the oldest owed byte
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (owed_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %b",
                                      rsp_item.packed_byte, rsp_item.last_of_run));
         end else begin
            want = owed_bytes.pop_front();
            bytes_checked++;
            if (rsp_item.packed_byte !== want.packed_byte)
               report_mismatch($sformatf("packed_byte: expected %02h got %02h",
                                         want.packed_byte, rsp_item.packed_byte));
            if (rsp_item.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run: expected %b got %b (byte %02h)",
                                         want.last_of_run, rsp_item.last_of_run,
                                         want.packed_byte));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      row_type    rows [$];
      req_type    it;
      int         r;
      int         gap;
      bit         no_idle;

      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      req_held = 1'b0;
      mismatches = 0;
      bytes_checked = 0;
      n_load = 0; n_encode = 0; n_flush = 0; n_unused = 0; n_four = 0;
      // model reset: lengths clear; bits are never read before a load
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         code_tbl[i] = '0;
         len_tbl[i]  = '0;
      end
      part_bits  = '0;
      part_count = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, every op and the corner cases.
      // nothing loaded yet: encode, flush and the unused op all stay silent
      rows = {rows, mk_row(OP_ENCODE, 8'h41, 32'h0, 6'd0, 0, 32'h0)};
      rows = {rows, mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, 0, 32'h0)};
      rows = {rows, mk_row(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 0, 32'h0)};
      // longest code, all ones: four full bytes
      rows = {rows, mk_row(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32, 0, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 4, 32'hFFFF_FFFF)};
      // over-long length saturates to 32; all-zero code
      rows = {rows, mk_row(OP_LOAD,   8'hFF, 32'h0, 6'd63, 0, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 4, 32'h0)};
      // bits above the length are ignored: 3-bit code 010
      rows = {rows, mk_row(OP_LOAD,   8'h01, 32'hFFFF_FFFA, 6'd3, 0, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 0, 32'h0)};
      rows = {rows, mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, 1, 32'h4000_0000)};
      // flush with nothing pending
      rows = {rows, mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, 0, 32'h0)};
      // load with length zero leaves the symbol unused
      rows = {rows, mk_row(OP_LOAD,   8'h02, 32'hDEAD_BEEF, 6'd0, 0, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h02, 32'h0, 6'd0, 0, 32'h0)};
      // unaligned runs, left to the model
      rows = {rows, mk_row(OP_LOAD,   8'h80, 32'h0000_0005, 6'd1, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h80, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_LOAD,   8'h7F, 32'hAAAA_AAAA, 6'd7, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h7F, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_LOAD,   8'h10, 32'h1234_5678, 6'd33, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h10, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_ENCODE, 8'h80, 32'h0, 6'd0, -1, 32'h0)};
      rows = {rows, mk_row(OP_FLUSH,  8'h00, 32'h0, 6'd0, -1, 32'h0)};

      foreach (rows[i]) issue_item(rows[i].item, rows[i].n_typed, rows[i].typed_bytes,
                                   pick_gap());

      // Sender holds off until the directed bytes have all drained.
      wait_idle();

      // Random part: mostly encodes of loaded symbols, with loads, flushes and noise.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // burst stretches with no idling at all
         no_idle = (k >= 60 && k < 90) || (k >= 200 && k < 230);
         it.symbol    = SYM_W'($urandom_range(0, 255));
         it.code_bits = $urandom;
         it.code_length = '0;
         r = $urandom_range(0, 99);
         if (r < 20 || coded_syms.size() == 0) begin
            it.op = OP_LOAD;
            r = $urandom_range(0, 99);
            if (r < 70)      it.code_length = LEN_W'($urandom_range(1, 12));
            else if (r < 90) it.code_length = LEN_W'($urandom_range(13, 32));
            else if (r < 95) it.code_length = '0;
            else             it.code_length = LEN_W'($urandom_range(33, 63));
         end else if (r < 80) begin
            it.op = OP_ENCODE;
            // mostly a loaded symbol; now and then any byte, loaded or not
            if ($urandom_range(0, 9) != 0)
               it.symbol = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
            it.code_length = LEN_W'($urandom_range(0, 63));
         end else if (r < 95) begin
            it.op = OP_FLUSH;
            it.code_length = LEN_W'($urandom_range(0, 63));
         end else begin
            it.op = OP_UNUSED;
            it.code_length = LEN_W'($urandom_range(0, 63));
         end
         gap = no_idle ? 0 : pick_gap();
         issue_item(it, -1, 32'h0, gap);
         // hold the sender once mid-run until all owed bytes are out
         if (k == RANDOM_ITEMS / 2) wait_idle();
      end

      wait_idle();

      $display("Ran %0d loads, %0d encodes, %0d flushes, %0d unused-op items;",
               n_load, n_encode, n_flush, n_unused);
      $display("%0d items made four bytes; checked %0d packed bytes, %0d mismatches.",
               n_four, bytes_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASS huffman_bit_packer");
      end else begin
         $display("FAIL huffman_bit_packer");
      end
      $finish;
   end

endmodule
